// ----- rtl/pbd_pkg.sv -----
// Shared types and constants for the padded block deframer.
package pbd_pkg;

   // Largest identifier length and the select width into its byte lanes.
   localparam int MAX_IDENT_BYTES = 16;
   localparam int IDENT_SEL_W     = 4;

   // Block header layout: command, content length, padding length.
   localparam int HDR_BYTES = 5;
   localparam logic [2:0] HDR_CMD    = 3'd0;
   localparam logic [2:0] HDR_LEN_HI = 3'd1;
   localparam logic [2:0] HDR_LEN_LO = 3'd2;
   localparam logic [2:0] HDR_PAD_HI = 3'd3;
   localparam logic [2:0] HDR_LAST   = 3'(HDR_BYTES - 1);

   // Block commands.
   localparam logic [7:0] CMD_CHAIN  = 8'd0;
   localparam logic [7:0] CMD_SWITCH = 8'd2;

   // Result kinds.
   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_EVENT = 1'b1;

   // Register select, taken from the 8-byte aligned address.
   localparam logic REG_IDENT_HIGH = 1'b0;
   localparam logic REG_IDENT_LOW  = 1'b1;

   // Source of the byte loaded into the result register.
   typedef enum logic [1:0] {
      OUT_SEL_INPUT,
      OUT_SEL_STORE,
      OUT_SEL_EVENT
   } out_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        match_step;
      logic        flush_step;
      logic        hdr_init;
      logic        hdr_step;
      logic        block_clear;
      logic        content_step;
      logic        pad_step;
      logic        out_load;
      out_sel_type out_sel;
      logic        out_last;
   } pbd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic slot_free;
      logic count_last;
      logic match_ok;
      logic hdr_last;
      logic content_nz;
      logic content_le1;
      logic pad_new_nz;
      logic pad_nz;
      logic pad_le1;
      logic is_chain;
      logic is_switch;
   } pbd_status_type;

endpackage

// ----- rtl/pbd_channels.sv -----
// Valid/ready channel interfaces for the input bytes and the results.
interface pbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       chunk_end;

   modport source (output valid, output in_byte, output chunk_end, input ready);
   modport sink (input valid, input in_byte, input chunk_end, output ready);
endinterface

interface pbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       item_kind;
   logic       run_last;

   modport source (output valid, output out_byte, output item_kind, output run_last,
                   input ready);
   modport sink (input valid, input out_byte, input item_kind, input run_last,
                 output ready);
endinterface

// ----- rtl/pbd_csr.sv -----
// APB-style register port holding the two identifier registers.
module pbd_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready,
   output logic [63:0] ident_high,
   output logic [63:0] ident_low
);
   import pbd_pkg::*;

   logic [63:0] ident_high_ff, ident_high_in;
   logic [63:0] ident_low_ff, ident_low_in;
   logic        wr_en;
   logic        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[3];

   // Register write decode.
   always_comb begin
      ident_high_in = ident_high_ff;
      ident_low_in  = ident_low_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_IDENT_HIGH: ident_high_in = csr_pwdata;
            REG_IDENT_LOW:  ident_low_in  = csr_pwdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ident_high_ff <= '0;
         ident_low_ff  <= '0;
      end else begin
         ident_high_ff <= ident_high_in;
         ident_low_ff  <= ident_low_in;
      end
   end

   // Read mux.
   assign csr_prdata = (reg_sel == REG_IDENT_LOW) ? ident_low_ff : ident_high_ff;
   assign ident_high = ident_high_ff;
   assign ident_low  = ident_low_ff;

endmodule

// ----- rtl/pbd_ctrl.sv -----
// Controller state machine: sequences identifier match, headers, content and padding.
module pbd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   chunk_end,
   output logic                   req_ready,
   input  pbd_pkg::pbd_status_type status,
   output pbd_pkg::pbd_cmd_type    cmd
);
   import pbd_pkg::*;

   localparam logic [2:0] ST_AWAIT   = 3'd0;
   localparam logic [2:0] ST_PASS    = 3'd1;
   localparam logic [2:0] ST_HEADER  = 3'd2;
   localparam logic [2:0] ST_CONTENT = 3'd3;
   localparam logic [2:0] ST_PADDING = 3'd4;
   localparam logic [2:0] ST_FLUSH   = 3'd5;
   localparam logic [2:0] ST_EVENT   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       end_ff, end_in;
   logic       accept;
   logic [2:0] after_now;
   logic [2:0] after_held;

   // Input is taken in the byte-consuming states while the result slot is free.
   always_comb begin
      req_ready = 1'b0;
      if ((state_ff != ST_FLUSH) && (state_ff != ST_EVENT)) begin
         req_ready = status.slot_free;
      end
   end

   assign accept     = req_valid && req_ready;
   assign after_now  = chunk_end ? ST_AWAIT : ST_PASS;
   assign after_held = end_ff ? ST_AWAIT : ST_PASS;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      end_in   = end_ff;
      cmd      = '0;
      cmd.out_sel = OUT_SEL_INPUT;
      unique case (state_ff)
         ST_AWAIT: begin
            if (accept) begin
               cmd.match_step = 1'b1;
               if (status.count_last) begin
                  if (status.match_ok) begin
                     cmd.hdr_init = 1'b1;
                     state_in = ST_HEADER;
                  end else begin
                     end_in   = chunk_end;
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_PASS: begin
            if (accept) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               if (chunk_end) begin
                  state_in = ST_AWAIT;
               end
            end
         end
         ST_HEADER: begin
            if (accept) begin
               cmd.hdr_step = 1'b1;
               if (status.hdr_last) begin
                  if (status.content_nz) begin
                     state_in = ST_CONTENT;
                  end else if (status.pad_new_nz) begin
                     state_in = ST_PADDING;
                  end else if (status.is_chain) begin
                     cmd.block_clear = 1'b1;
                     state_in = ST_HEADER;
                  end else begin
                     // The event is the only result of this byte.
                     if (status.is_switch) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_SEL_EVENT;
                        cmd.out_last = 1'b1;
                     end
                     state_in = after_now;
                  end
               end
            end
         end
         ST_CONTENT: begin
            if (accept) begin
               cmd.content_step = 1'b1;
               cmd.out_load     = 1'b1;
               cmd.out_last     = 1'b1;
               if (status.content_le1) begin
                  if (status.pad_nz) begin
                     state_in = ST_PADDING;
                  end else if (status.is_chain) begin
                     cmd.block_clear = 1'b1;
                     state_in = ST_HEADER;
                  end else if (status.is_switch) begin
                     // The data byte goes first; the event follows from ST_EVENT once the result slot is free.
                     cmd.out_last = 1'b0;
                     end_in   = chunk_end;
                     state_in = ST_EVENT;
                  end else begin
                     state_in = after_now;
                  end
               end
            end
         end
         ST_PADDING: begin
            if (accept) begin
               cmd.pad_step = 1'b1;
               if (status.pad_le1) begin
                  if (status.is_chain) begin
                     cmd.block_clear = 1'b1;
                     state_in = ST_HEADER;
                  end else begin
                     if (status.is_switch) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_SEL_EVENT;
                        cmd.out_last = 1'b1;
                     end
                     state_in = after_now;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (status.slot_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_sel    = OUT_SEL_STORE;
               cmd.flush_step = 1'b1;
               cmd.out_last   = status.count_last;
               if (status.count_last) begin
                  state_in = after_held;
               end
            end
         end
         ST_EVENT: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_SEL_EVENT;
               cmd.out_last = 1'b1;
               state_in = after_held;
            end
         end
         default: begin
            state_in = ST_AWAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_AWAIT;
         end_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         end_ff   <= end_in;
      end
   end

endmodule

// ----- rtl/pbd_datapath.sv -----
// Datapath: match buffer, counters, header fields, length counters and result register.
module pbd_datapath #(
   parameter int IDENT_BYTES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             in_byte,
   input  logic [63:0]            ident_high,
   input  logic [63:0]            ident_low,
   input  pbd_pkg::pbd_cmd_type    cmd,
   output pbd_pkg::pbd_status_type status,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_item_kind,
   output logic                   rsp_run_last
);
   import pbd_pkg::*;

   localparam int IDX_W = (IDENT_BYTES > 1) ? $clog2(IDENT_BYTES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(IDENT_BYTES - 1);

   logic [7:0]       store_ff [IDENT_BYTES];
   logic [IDX_W-1:0] count_ff, count_in;
   logic             good_ff, good_in;
   logic [2:0]       hidx_ff, hidx_in;
   logic [7:0]       block_cmd_ff, block_cmd_in;
   logic [15:0]      content_ff, content_in;
   logic [15:0]      pad_ff, pad_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_kind_ff, rsp_kind_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [7:0]       ident_bytes [MAX_IDENT_BYTES];
   logic [7:0]       ident_cur;
   logic [7:0]       store_rd;
   logic             count_last;
   logic             match_ok;

   // Identifier split into byte lanes, byte 0 at the top of the high register.
   always_comb begin
      for (int k = 0; k < MAX_IDENT_BYTES / 2; k++) begin
         ident_bytes[k]                       = ident_high[63 - 8 * k -: 8];
         ident_bytes[k + MAX_IDENT_BYTES / 2] = ident_low[63 - 8 * k -: 8];
      end
   end

   assign ident_cur  = ident_bytes[IDENT_SEL_W'(count_ff)];
   assign store_rd   = store_ff[count_ff];
   assign count_last = (count_ff == LAST_IDX);
   assign match_ok   = good_ff && (in_byte == ident_cur);

   // Status toward the controller.
   always_comb begin
      status              = '0;
      status.slot_free    = !rsp_valid_ff || rsp_ready;
      status.count_last   = count_last;
      status.match_ok     = match_ok;
      status.hdr_last     = (hidx_ff == HDR_LAST);
      status.content_nz   = (content_ff != 16'd0);
      status.content_le1  = (content_ff <= 16'd1);
      status.pad_new_nz   = ({pad_ff[15:8], in_byte} != 16'd0);
      status.pad_nz       = (pad_ff != 16'd0);
      status.pad_le1      = (pad_ff <= 16'd1);
      status.is_chain     = (block_cmd_ff == CMD_CHAIN);
      status.is_switch    = (block_cmd_ff == CMD_SWITCH);
   end

   // Shared byte counter: identifier compare, then the flush of the buffer.
   always_comb begin
      count_in = count_ff;
      good_in  = good_ff;
      if (cmd.match_step || cmd.flush_step) begin
         count_in = count_last ? '0 : count_ff + IDX_W'(1);
      end
      if (cmd.match_step) begin
         good_in = count_last ? 1'b1 : match_ok;
      end
   end

   // Header fields and the content and padding counters.
   always_comb begin
      hidx_in      = hidx_ff;
      block_cmd_in = block_cmd_ff;
      content_in   = content_ff;
      pad_in       = pad_ff;
      if (cmd.hdr_init) begin
         hidx_in      = '0;
         block_cmd_in = CMD_CHAIN;
         content_in   = '0;
         pad_in       = '0;
      end else if (cmd.hdr_step) begin
         unique case (hidx_ff)
            HDR_CMD:    block_cmd_in = in_byte;
            HDR_LEN_HI: content_in   = {in_byte, 8'h00};
            HDR_LEN_LO: content_in   = {content_ff[15:8], in_byte};
            HDR_PAD_HI: pad_in       = {in_byte, 8'h00};
            default:    pad_in       = {pad_ff[15:8], in_byte};
         endcase
         hidx_in = (hidx_ff == HDR_LAST) ? '0 : hidx_ff + 3'd1;
      end else begin
         if (cmd.content_step && (content_ff != 16'd0)) begin
            content_in = content_ff - 16'd1;
         end
         if (cmd.pad_step && (pad_ff != 16'd0)) begin
            pad_in = pad_ff - 16'd1;
         end
      end
      // A continuing block clears its lengths for the next header.
      if (cmd.block_clear) begin
         hidx_in    = '0;
         content_in = '0;
         pad_in     = '0;
      end
   end

   // Result register: loaded from the input byte, the buffer or as an event.
   always_comb begin
      rsp_byte_in  = rsp_byte_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = cmd.out_last;
         unique case (cmd.out_sel)
            OUT_SEL_INPUT: begin
               rsp_byte_in = in_byte;
               rsp_kind_in = KIND_DATA;
            end
            OUT_SEL_STORE: begin
               rsp_byte_in = store_rd;
               rsp_kind_in = KIND_DATA;
            end
            default: begin
               rsp_byte_in = 8'h00;
               rsp_kind_in = KIND_EVENT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         good_ff      <= 1'b1;
         hidx_ff      <= '0;
         block_cmd_ff <= CMD_CHAIN;
         content_ff   <= '0;
         pad_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         good_ff      <= good_in;
         hidx_ff      <= hidx_in;
         block_cmd_ff <= block_cmd_in;
         content_ff   <= content_in;
         pad_ff       <= pad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Buffer of the bytes seen while awaiting the identifier.
   always_ff @(posedge clock) begin
      if (cmd.match_step) begin
         store_ff[count_ff] <= in_byte;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_item_kind = rsp_kind_ff;
   assign rsp_run_last  = rsp_last_ff;

endmodule

// ----- rtl/padded_block_deframer.sv -----
// Top level: passed and content bytes are registered as results in the cycle after input.
// Throughput: one byte per cycle unless results stall, set by the single result register.
// An identifier mismatch holds off input while the buffer drains in ST_FLUSH;
// a switch block ending on a content byte also holds off input until its event is loaded.
// Reset is synchronous: it clears the controller, counters, result valid and identifiers.
// The match buffer is not cleared; only entries written in the current compare are read.
module padded_block_deframer #(
   parameter int IDENT_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   pbd_req_if.sink     req_chan,
   pbd_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import pbd_pkg::*;

   logic [63:0]    ident_high;
   logic [63:0]    ident_low;
   pbd_cmd_type    cmd;
   pbd_status_type status;
   logic           req_ready;

   // Identifier registers.
   pbd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .ident_high  (ident_high),
      .ident_low   (ident_low)
   );

   // Sequencing.
   pbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .chunk_end (req_chan.chunk_end),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and result register.
   pbd_datapath #(
      .IDENT_BYTES (IDENT_BYTES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .in_byte       (req_chan.in_byte),
      .ident_high    (ident_high),
      .ident_low     (ident_low),
      .cmd           (cmd),
      .status        (status),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_out_byte  (rsp_chan.out_byte),
      .rsp_item_kind (rsp_chan.item_kind),
      .rsp_run_last  (rsp_chan.run_last)
   );

   assign req_chan.ready = req_ready;

endmodule

// ----- rtl/pbd_checker.sv -----
// Port-level assertions for the deframer, bound to the top level.
module pbd_port_checks (
   input logic       clock,
   input logic       reset,
   pbd_req_if.sink   req_chan,
   pbd_rsp_if.source rsp_chan
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=>
         (rsp_chan.valid && $stable(rsp_chan.out_byte) && $stable(rsp_chan.item_kind)
          && $stable(rsp_chan.run_last)))
      else $error("result changed while stalled");

   // An event result carries a zero byte and closes its run.
   a_event_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.item_kind) |-> (rsp_chan.out_byte == 8'h00 &&
                                                  rsp_chan.run_last))
      else $error("malformed event result");

   // The rest of a run follows without a gap.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.run_last) |=> rsp_chan.valid)
      else $error("gap inside a run of results");

   // No input is taken while a result is stalled.
   a_no_take_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input taken while result stalled");

   // Reset leaves no result pending.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid after reset");

endmodule

bind padded_block_deframer pbd_port_checks u_pbd_port_checks (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

// ----- bench/pbd_checker.sv -----
// Checker for the padded block deframer: predicts every result and compares it.
module pbd_checker #(
   parameter int IDENT_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   pbd_req_if          req,
   pbd_rsp_if          rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import pbd_pkg::*;

   typedef enum logic [2:0] {
      AWAIT_IDENT,
      PASS_THROUGH,
      IN_HEADER,
      IN_CONTENT,
      IN_PADDING
   } parse_mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       item_kind;
      logic       run_last;
   } deframed_item_type;

   // Shadow of the identifier registers and of the parser state.
   logic [63:0]    ident_high;
   logic [63:0]    ident_low;
   parse_mode_type mode;
   logic [7:0]     match_store [MAX_IDENT_BYTES];
   logic [4:0]     match_count;
   logic           match_good;
   logic [2:0]     header_index;
   logic [7:0]     block_command;
   logic [15:0]    content_left;
   logic [15:0]    padding_left;

   // Results of the byte being parsed, and all results still owed by the block.
   deframed_item_type byte_results[$];
   deframed_item_type expected_items[$];

   function automatic logic [7:0] ident_byte(logic [3:0] k);
      logic [127:0] ident_all;
      ident_all = {ident_high, ident_low};
      return ident_all[127 - 8 * k -: 8];
   endfunction

   function automatic void emit(logic [7:0] b, logic kind);
      byte_results.push_back('{b, kind, 1'b0});
   endfunction

   // A continue block is followed by another header; any other command ends the framing.
   function automatic void finish_block(logic chunk_end);
      if (block_command == CMD_CHAIN) begin
         mode = IN_HEADER;
         header_index = '0;
         content_left = '0;
         padding_left = '0;
      end else begin
         if (block_command == CMD_SWITCH) begin
            emit('0, KIND_EVENT);
         end
         mode = chunk_end ? AWAIT_IDENT : PASS_THROUGH;
      end
   endfunction

   // Works out the results of one accepted input byte and queues them.
   function automatic void predict_deframe(logic [7:0] b, logic chunk_end);
      byte_results.delete();
      case (mode)
         AWAIT_IDENT: begin
            match_store[match_count[3:0]] = b;
            if (b != ident_byte(match_count[3:0])) begin
               match_good = 1'b0;
            end
            match_count++;
            if (match_count >= IDENT_BYTES) begin
               if (match_good) begin
                  mode = IN_HEADER;
                  header_index = '0;
                  block_command = '0;
                  content_left = '0;
                  padding_left = '0;
               end else begin
                  for (int k = 0; k < match_count; k++) begin
                     emit(match_store[k], KIND_DATA);
                  end
                  mode = chunk_end ? AWAIT_IDENT : PASS_THROUGH;
               end
               match_count = '0;
               match_good = 1'b1;
            end
         end
         PASS_THROUGH: begin
            emit(b, KIND_DATA);
            if (chunk_end) begin
               mode = AWAIT_IDENT;
            end
         end
         IN_HEADER: begin
            case (header_index)
               HDR_CMD:    block_command = b;
               HDR_LEN_HI: content_left = {b, 8'h00};
               HDR_LEN_LO: content_left[7:0] = b;
               HDR_PAD_HI: padding_left = {b, 8'h00};
               default:    padding_left[7:0] = b;
            endcase
            if (header_index == HDR_LAST) begin
               header_index = '0;
               if (content_left != 0) begin
                  mode = IN_CONTENT;
               end else if (padding_left != 0) begin
                  mode = IN_PADDING;
               end else begin
                  finish_block(chunk_end);
               end
            end else begin
               header_index++;
            end
         end
         IN_CONTENT: begin
            emit(b, KIND_DATA);
            if (content_left != 0) begin
               content_left--;
            end
            if (content_left == 0) begin
               if (padding_left != 0) begin
                  mode = IN_PADDING;
               end else begin
                  finish_block(chunk_end);
               end
            end
         end
         IN_PADDING: begin
            if (padding_left != 0) begin
               padding_left--;
            end
            if (padding_left == 0) begin
               finish_block(chunk_end);
            end
         end
         default: mode = AWAIT_IDENT;
      endcase
      if (byte_results.size() > 0) begin
         byte_results[byte_results.size() - 1].run_last = 1'b1;
      end
      foreach (byte_results[k]) begin
         expected_items.push_back(byte_results[k]);
      end
   endfunction

   function automatic void report_field(string field, logic [7:0] want, logic [7:0] got);
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
   endfunction

   // Watch register writes and both channels at every rising edge.
   always @(posedge clock) begin : watch
      deframed_item_type want;
      if (reset) begin
         ident_high = '0;
         ident_low = '0;
         mode = AWAIT_IDENT;
         match_count = '0;
         match_good = 1'b1;
         header_index = '0;
         block_command = '0;
         content_left = '0;
         padding_left = '0;
         expected_items.delete();
         fail_count = 0;
         pending <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[3] == REG_IDENT_LOW) begin
               ident_low = csr_pwdata;
            end else begin
               ident_high = csr_pwdata;
            end
         end

         if (req.valid && req.ready) begin
            predict_deframe(req.in_byte, req.chunk_end);
         end

         // Each result transaction is matched against the oldest expectation.
         if (rsp.valid && rsp.ready) begin
            if (expected_items.size() == 0) begin
               $display({"%0t ns: unexpected result, expected none, ",
                         "actual byte %0h kind %0b last %0b"},
                        $time, rsp.out_byte, rsp.item_kind, rsp.run_last);
               fail_count++;
            end else begin
               want = expected_items.pop_front();
               if (rsp.out_byte !== want.out_byte) begin
                  report_field("out_byte", want.out_byte, rsp.out_byte);
               end
               if (rsp.item_kind !== want.item_kind) begin
                  report_field("item_kind", 8'(want.item_kind), 8'(rsp.item_kind));
               end
               if (rsp.run_last !== want.run_last) begin
                  report_field("run_last", 8'(want.run_last), 8'(rsp.run_last));
               end
            end
         end
         pending <= expected_items.size();
      end
   end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the padded block deframer: clock, reset, stimulus and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pbd_pkg::*;

   localparam int IDENT_LEN     = 16;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int DRAIN_CYCLES  = 2 * IDENT_LEN + 4;
   localparam int RANDOM_ITEMS  = 30;
   localparam logic [3:0] ADDR_IDENT_HIGH = {REG_IDENT_HIGH, 3'b000};
   localparam logic [3:0] ADDR_IDENT_LOW  = {REG_IDENT_LOW, 3'b000};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;

   // Stimulus state: identifier bytes in stream order, idling and chunk marking controls.
   logic [7:0]  ident [IDENT_LEN];
   bit          quiet;
   bit          chunk_noise;
   int          sent_items;

   pbd_req_if req_chan ();
   pbd_rsp_if rsp_chan ();

   padded_block_deframer #(
      .IDENT_BYTES(IDENT_LEN)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pbd_checker #(
      .IDENT_BYTES(IDENT_LEN)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Idle lengths: mostly none, some short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic bit noise_end();
      return $urandom_range(0, 9) == 0;
   endfunction

   function automatic logic [15:0] pick_len();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return '0;
      if (r < 9) return 16'($urandom_range(1, 6));
      return 16'($urandom_range(7, 40));
   endfunction

   function automatic logic [7:0] other_cmd();
      logic [7:0] c;
      do c = 8'($urandom); while (c == CMD_CHAIN || c == CMD_SWITCH);
      return c;
   endfunction

   // One input transaction, then an optional gap with valid low.
   task automatic send_byte(input logic [7:0] b, input logic chunk_end);
      int gap;
      req_chan.valid <= 1'b1;
      req_chan.in_byte <= b;
      req_chan.chunk_end <= chunk_end;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_items++;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic sender_idle();
      req_chan.valid <= 1'b0;
   endtask

   // Hold the sender until every expected result has come back.
   task automatic drain_results();
      sender_idle();
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic settle();
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [3:0] addr, input logic [63:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [63:0] high_word, input logic [63:0] low_word);
      csr_write(ADDR_IDENT_HIGH, high_word);
      csr_write(ADDR_IDENT_LOW, low_word);
      for (int k = 0; k < 8; k++) begin
         ident[k] = high_word[63 - 8 * k -: 8];
         ident[k + 8] = low_word[63 - 8 * k -: 8];
      end
   endtask

   // Identifier bytes; bad_at corrupts one byte, scramble makes all bytes random.
   task automatic send_ident(input int bad_at, input bit scramble, input int split_at,
                             output bit ended);
      logic [7:0] b;
      logic       e;
      e = 1'b0;
      for (int k = 0; k < IDENT_LEN; k++) begin
         b = scramble ? 8'($urandom) : ident[k];
         if (k == bad_at) begin
            b = ident[k] ^ 8'($urandom_range(1, 255));
         end else if (scramble && k == 0 && b == ident[0]) begin
            b = ~b;
         end
         e = (k == split_at) || (chunk_noise && noise_end());
         send_byte(b, e);
      end
      ended = e;
   endtask

   // One block: header, content and padding; mid_end marks chunk ends inside it.
   task automatic send_block(input logic [7:0] cmd, input logic [15:0] clen,
                             input logic [15:0] plen, input bit mid_end, input bit end_last);
      int         total;
      logic [7:0] b;
      logic       e;
      total = HDR_BYTES + int'(clen) + int'(plen);
      for (int i = 0; i < total; i++) begin
         case (i)
            HDR_CMD:    b = cmd;
            HDR_LEN_HI: b = clen[15:8];
            HDR_LEN_LO: b = clen[7:0];
            HDR_PAD_HI: b = plen[15:8];
            HDR_LAST:   b = plen[7:0];
            default:    b = 8'($urandom);
         endcase
         e = (i == total - 1) ? end_last : (mid_end || (chunk_noise && noise_end()));
         send_byte(b, e);
      end
   endtask

   task automatic send_tail(input int n);
      for (int i = 0; i < n; i++) begin
         send_byte(8'($urandom), i == n - 1);
      end
   endtask

   // A matching identifier, some continue blocks and a closing block.
   task automatic good_frame(input logic [7:0] last_cmd);
      bit ended;
      bit close;
      send_ident(-1, 1'b0, -1, ended);
      repeat ($urandom_range(0, 3)) begin
         send_block(CMD_CHAIN, pick_len(), pick_len(), 1'b0, chunk_noise && noise_end());
      end
      close = ($urandom_range(0, 2) == 0);
      send_block(last_cmd, pick_len(), pick_len(), 1'b0, close);
      if (!close) begin
         send_tail($urandom_range(1, 6));
      end
   endtask

   task automatic broken_frame(input int bad_at, input bit scramble);
      bit ended;
      send_ident(bad_at, scramble, -1, ended);
      if (!ended) begin
         send_tail($urandom_range(1, 8));
      end
   endtask

   task automatic random_traffic(input int count);
      int goal;
      int r;
      goal = sent_items + count;
      chunk_noise = 1'b1;
      while (sent_items < goal) begin
         quiet = ($urandom_range(0, 5) == 0);
         r = $urandom_range(0, 9);
         if (r < 4) begin
            good_frame(CMD_SWITCH);
         end else if (r < 7) begin
            good_frame(other_cmd());
         end else if (r < 9) begin
            broken_frame($urandom_range(0, IDENT_LEN - 1), 1'b0);
         end else begin
            broken_frame(0, 1'b1);
         end
         if ($urandom_range(0, 7) == 0) begin
            drain_results();
         end
      end
      quiet = 1'b0;
      chunk_noise = 1'b0;
   endtask

   // Result side stalls, skipped in quiet stretches.
   initial begin : rsp_stall
      int n;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      forever begin
         n = quiet ? 0 : pick_gap();
         if (n > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t ns: timeout after %0d cycles", $time, CYCLE_LIMIT);
      $display("** padded_block_deframer: FAILED **");
      $finish;
   end

   initial begin : stimulus
      bit ended;
      req_chan.valid = 1'b0;
      req_chan.in_byte = '0;
      req_chan.chunk_end = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      quiet = 1'b0;
      chunk_noise = 1'b0;
      sent_items = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames with an all-zero identifier.
      configure('0, '0);
      send_ident(-1, 1'b0, 7, ended);
      send_block(CMD_CHAIN, 16'd0, 16'd0, 1'b1, 1'b0);
      send_block(CMD_CHAIN, 16'd3, 16'd2, 1'b1, 1'b0);
      send_block(CMD_SWITCH, 16'd2, 16'd0, 1'b0, 1'b1);
      send_ident(-1, 1'b0, -1, ended);
      send_block(CMD_SWITCH, 16'd0, 16'd0, 1'b0, 1'b0);
      send_tail(2);
      send_ident(-1, 1'b0, -1, ended);
      send_block(CMD_SWITCH, 16'd0, 16'd2, 1'b0, 1'b1);
      send_ident(IDENT_LEN - 1, 1'b0, IDENT_LEN - 1, ended);
      settle();

      // All-ones identifier with content-only and padding-only blocks, without idling.
      configure('1, '1);
      quiet = 1'b1;
      send_ident(-1, 1'b0, -1, ended);
      send_block(CMD_CHAIN, 16'd3, 16'd0, 1'b0, 1'b0);
      send_block(CMD_CHAIN, 16'd0, 16'd3, 1'b0, 1'b0);
      send_block(8'hFF, 16'd0, 16'd1, 1'b0, 1'b1);
      quiet = 1'b0;
      settle();

      // Random traffic under two random identifiers.
      repeat (2) begin
         configure({$urandom, $urandom}, {$urandom, $urandom});
         random_traffic(RANDOM_ITEMS / 2);
         settle();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("** padded_block_deframer: PASSED **");
      end else begin
         $display("** padded_block_deframer: FAILED **");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/pbd_pkg.sv
rtl/pbd_channels.sv
rtl/pbd_csr.sv
rtl/pbd_ctrl.sv
rtl/pbd_datapath.sv
rtl/padded_block_deframer.sv
rtl/pbd_checker.sv
bench/pbd_checker.sv
bench/tb.sv
